// File: src/ptord_pkg.sv
// Shared constants and types for the point order sorter.
`timescale 1ns / 1ps
package ptord_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_BITS = 32;

  localparam int COORD_W   = 32;
  localparam int OUT_IDX_W = 6;
  localparam int IDX_W     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W     = $clog2(MAX_POINTS + 1);
  localparam int SHIFT_W   = 7;
  localparam int SEL_W     = 2;
  localparam int ADDR_W    = 4;
  localparam int APB_W     = 32;

  localparam logic [SEL_W-1:0] MODE_X      = 2'd0;
  localparam logic [SEL_W-1:0] MODE_Y      = 2'd1;
  localparam logic [SEL_W-1:0] MODE_Z      = 2'd2;
  localparam logic [SEL_W-1:0] MODE_ROTATE = 2'd3;

  localparam logic [1:0] REG_KEY_SEL = 2'd0;
  localparam logic [1:0] REG_SHIFT   = 2'd1;
  localparam logic [1:0] REG_REVERSE = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] key;
    logic        [IDX_W-1:0]      idx;
  } entry_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic             re;
    logic [IDX_W-1:0] raddr;
  } store_req_t;

endpackage

// File: src/ptord_store.sv
// Sorted entry memory: one write port, one registered read port.
`timescale 1ns / 1ps
module ptord_store (
  input  logic                  clk,
  input  ptord_pkg::store_req_t req,
  output ptord_pkg::entry_t     rd_data
);

  ptord_pkg::entry_t mem [ptord_pkg::MAX_POINTS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// File: src/ptord_seq.sv
// Insertion walk, offset reduction and result sequencing.
`timescale 1ns / 1ps
module ptord_seq (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [ptord_pkg::SEL_W-1:0]         key_select,
  input  logic [ptord_pkg::SHIFT_W-1:0]       shift_offset,
  input  logic                                reverse_order,
  input  logic                                s_valid,
  output logic                                s_ready,
  input  logic signed [ptord_pkg::COORD_BITS-1:0] s_key,
  input  logic                                s_last,
  output logic                                m_valid,
  input  logic                                m_ready,
  output logic [ptord_pkg::OUT_IDX_W-1:0]     m_index,
  output logic                                m_last,
  output logic                                m_ovf,
  output ptord_pkg::store_req_t               mem_req,
  input  ptord_pkg::entry_t                   rd_data
);

  localparam int IDX_W   = ptord_pkg::IDX_W;
  localparam int CNT_W   = ptord_pkg::CNT_W;
  localparam int SHIFT_W = ptord_pkg::SHIFT_W;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_WALK  = 6'b000010,
    ST_PLACE = 6'b000100,
    ST_MOD   = 6'b001000,
    ST_READ  = 6'b010000,
    ST_SHOW  = 6'b100000
  } state_t;

  state_t                               state, state_next;
  logic [CNT_W-1:0]                     count, count_next;
  logic                                 ovf, ovf_next;
  logic signed [ptord_pkg::COORD_BITS-1:0] key, key_next;
  logic                                 fin, fin_next;
  logic [IDX_W-1:0]                     pos, pos_next;
  logic [SHIFT_W-1:0]                   off, off_next;
  logic [IDX_W-1:0]                     src, src_next;
  logic [IDX_W-1:0]                     k, k_next;

  logic [SHIFT_W-1:0] n_ext;
  logic [CNT_W-1:0]   off_cnt;
  logic [IDX_W-1:0]   last_idx;
  logic [IDX_W-1:0]   new_idx;
  logic               rotate;
  logic               is_last;

  assign n_ext    = SHIFT_W'(count);
  assign off_cnt  = CNT_W'(off);
  assign last_idx = IDX_W'(count - CNT_W'(1));
  assign new_idx  = IDX_W'(count);
  assign rotate   = (key_select == ptord_pkg::MODE_ROTATE);
  assign is_last  = (k == last_idx);

  assign m_valid = (state == ST_SHOW);
  assign m_index = rotate ? ptord_pkg::OUT_IDX_W'(src) : ptord_pkg::OUT_IDX_W'(rd_data.idx);
  assign m_last  = is_last;
  assign m_ovf   = ovf;
  assign s_ready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    key_next   = key;
    fin_next   = fin;
    pos_next   = pos;
    off_next   = off;
    src_next   = src;
    k_next     = k;
    mem_req    = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_valid) begin
          key_next = s_key;
          fin_next = s_last;
          if (count == CNT_W'(ptord_pkg::MAX_POINTS)) begin
            ovf_next = 1'b1;
            if (s_last) begin
              off_next   = shift_offset;
              state_next = ST_MOD;
            end
          end else begin
            pos_next = new_idx;
            if (count == '0) begin
              state_next = ST_PLACE;
            end else begin
              mem_req.re    = 1'b1;
              mem_req.raddr = new_idx - IDX_W'(1);
              state_next    = ST_WALK;
            end
          end
        end
      end
      ST_WALK: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = pos;
        if (rd_data.key > key) begin
          mem_req.wdata = rd_data;
          pos_next      = pos - IDX_W'(1);
          if (pos == IDX_W'(1)) begin
            state_next = ST_PLACE;
          end else begin
            mem_req.re    = 1'b1;
            mem_req.raddr = pos - IDX_W'(2);
          end
        end else begin
          mem_req.wdata.key = key;
          mem_req.wdata.idx = new_idx;
          count_next        = count + CNT_W'(1);
          if (fin) begin
            off_next   = shift_offset;
            state_next = ST_MOD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PLACE: begin
        mem_req.we        = 1'b1;
        mem_req.waddr     = pos;
        mem_req.wdata.key = key;
        mem_req.wdata.idx = new_idx;
        count_next        = count + CNT_W'(1);
        if (fin) begin
          off_next   = shift_offset;
          state_next = ST_MOD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (off >= n_ext) begin
          off_next = off - n_ext;
        end else begin
          k_next = '0;
          if (reverse_order) begin
            pos_next = last_idx;
            src_next = IDX_W'(count - CNT_W'(1) - off_cnt);
          end else begin
            pos_next = '0;
            src_next = (off == '0) ? '0 : IDX_W'(count - off_cnt);
          end
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        mem_req.re    = 1'b1;
        mem_req.raddr = pos;
        state_next    = ST_SHOW;
      end
      ST_SHOW: begin
        if (m_ready) begin
          if (is_last) begin
            count_next = '0;
            ovf_next   = 1'b0;
            state_next = ST_IDLE;
          end else begin
            k_next = k + IDX_W'(1);
            if (reverse_order) begin
              pos_next = pos - IDX_W'(1);
              src_next = (src == '0) ? last_idx : src - IDX_W'(1);
            end else begin
              pos_next = pos + IDX_W'(1);
              src_next = (src == last_idx) ? '0 : src + IDX_W'(1);
            end
            state_next = ST_READ;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
    key <= key_next;
    fin <= fin_next;
    pos <= pos_next;
    off <= off_next;
    src <= src_next;
    k   <= k_next;
  end

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !mem_req.we) else $error("store write while idle");
  a_result_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_valid |-> (count != '0)) else $error("result with empty set");
  a_walk_pos: assert property (@(posedge clk) disable iff (rst)
    (state == ST_WALK) |-> (pos != '0 && CNT_W'(pos) <= count))
    else $error("walk position out of range");
  a_offset_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (off < n_ext)) else $error("offset not reduced");
  a_show_holds: assert property (@(posedge clk) disable iff (rst)
    (m_valid && !m_ready) |=> (m_valid && $stable(k) && $stable(src)))
    else $error("pending result changed");

endmodule

// File: src/point_order_sorter_core.sv
// Top level: configuration registers, key selection and sorter core.
`timescale 1ns / 1ps
// channel  | dir | handshake        | payload
// s_*      | in  | tvalid/tready    | tdata x,y,z; tlast final point
// m_*      | out | tvalid/tready    | tdata source index; tlast end; tuser overflow
// apb      | in  | psel/penable     | key_select, shift_offset, reverse_order
// A point is placed by a read-compare-write walk over the entry memory that
// moves each stored entry with a larger key up by one place.
// On the final point, shift_offset is reduced modulo n by repeated subtraction,
// then each result passes a memory read state, then a show state.
// Reset clears the point count and overflow flag; the memory needs no clearing.
// While results are pending no point is taken; a stalled result holds.
module point_order_sorter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [95:0]                   s_tdata,   // coord_x, coord_y, coord_z
  input  logic                          s_tlast,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // source_index, zero fill
  output logic                          m_tlast,
  output logic [0:0]                    m_tuser,   // overflowed
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptord_pkg::ADDR_W-1:0]  paddr,
  input  logic [ptord_pkg::APB_W-1:0]   pwdata,
  output logic [ptord_pkg::APB_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CW = ptord_pkg::COORD_W;

  logic [ptord_pkg::SEL_W-1:0]   key_select;
  logic [ptord_pkg::SHIFT_W-1:0] shift_offset;
  logic                          reverse_order;

  logic                                  wr_en;
  logic [CW-1:0]                         field;
  logic signed [ptord_pkg::COORD_BITS-1:0] s_key;
  logic [ptord_pkg::OUT_IDX_W-1:0]       m_index;
  ptord_pkg::store_req_t                 mem_req;
  ptord_pkg::entry_t                     rd_data;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_select    <= '0;
      shift_offset  <= '0;
      reverse_order <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[ptord_pkg::ADDR_W-1:2])
        ptord_pkg::REG_KEY_SEL: key_select    <= pwdata[ptord_pkg::SEL_W-1:0];
        ptord_pkg::REG_SHIFT:   shift_offset  <= pwdata[ptord_pkg::SHIFT_W-1:0];
        ptord_pkg::REG_REVERSE: reverse_order <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[ptord_pkg::ADDR_W-1:2])
      ptord_pkg::REG_KEY_SEL: prdata = ptord_pkg::APB_W'(key_select);
      ptord_pkg::REG_SHIFT:   prdata = ptord_pkg::APB_W'(shift_offset);
      ptord_pkg::REG_REVERSE: prdata = ptord_pkg::APB_W'(reverse_order);
      default:                prdata = '0;
    endcase
  end

  always_comb begin
    case (key_select)
      ptord_pkg::MODE_Y: field = s_tdata[2*CW-1:CW];
      ptord_pkg::MODE_Z: field = s_tdata[3*CW-1:2*CW];
      default:           field = s_tdata[CW-1:0];
    endcase
  end

  assign s_key = field[ptord_pkg::COORD_BITS-1:0];

  ptord_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .key_select   (key_select),
    .shift_offset (shift_offset),
    .reverse_order(reverse_order),
    .s_valid      (s_tvalid),
    .s_ready      (s_tready),
    .s_key        (s_key),
    .s_last       (s_tlast),
    .m_valid      (m_tvalid),
    .m_ready      (m_tready),
    .m_index      (m_index),
    .m_last       (m_tlast),
    .m_ovf        (m_tuser[0]),
    .mem_req      (mem_req),
    .rd_data      (rd_data)
  );

  ptord_store u_store (
    .clk    (clk),
    .req    (mem_req),
    .rd_data(rd_data)
  );

  assign m_tdata = 8'(m_index);

endmodule
